// File: rtl/core/ise_pkg.sv
// Shared constants and types for the insertion sort engine.
package ise_pkg;

  localparam int DEPTH  = 64;
  localparam int DATA_W = 32;

  typedef logic signed [DATA_W-1:0] data_t;

  // What one cell shows its neighbors.
  typedef struct packed {
    logic  valid;
    logic  gt;
    data_t value;
  } cell_link_t;

  // Per-cycle command broadcast to every cell.
  typedef struct packed {
    logic  ins;
    logic  shift;
    data_t x;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_LOAD  = 2'b01,
    ST_DRAIN = 2'b10
  } ise_state_t;

endpackage

// File: rtl/core/ise_if.sv
// Valid/ready channel interfaces for the input and result items.
interface ise_in_if import ise_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t value;
  logic  final_req;

  modport source (output valid, output value, output final_req, input ready);
  modport sink   (input valid, input value, input final_req, output ready);
endinterface

interface ise_out_if import ise_pkg::*; ();
  logic  valid;
  logic  ready;
  data_t sorted_value;
  logic  end_of_list;
  logic  overflow;

  modport source (output valid, output sorted_value, output end_of_list,
                  output overflow, input ready);
  modport sink   (input valid, input sorted_value, input end_of_list,
                  input overflow, output ready);
endinterface

// File: rtl/core/insertion_sort_engine_unit.sv
// Top level of the insertion sort engine: cell chain and drain control.
//
// Usage: values enter on in_ch, one item per cycle while loading. Each item
// is placed at once into a chain of DEPTH cells kept in ascending order;
// equal values keep arrival order. An item with final_req set is inserted
// in its accept cycle, after which the block drains the list on out_ch,
// smallest first, one item per cycle, end_of_list on the largest entry and
// overflow on every item if values were dropped for lack of room.
// The first result is valid in the cycle after the final item is
// accepted. Throughput: one input per cycle while loading; a list of n
// entries drains in n taken results, during which in_ch.ready is low. The drain
// rate is set by the chain shifting one cell toward the output per taken
// result. A stalled receiver simply holds the chain and the shown item.
// Reset (synchronous, rst_n low) empties the chain and clears the flag;
// no clearing pass is needed since every cell has its own valid bit.
module insertion_sort_engine_unit import ise_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ise_in_if.sink    in_ch,
  ise_out_if.source out_ch
);

  ise_state_t state_r, state_nxt;
  logic       dropped_r, dropped_nxt;
  cell_link_t link [DEPTH];
  cell_link_t edge_left;
  cell_link_t edge_right;
  cell_ctrl_t ctrl;
  logic       in_acc;
  logic       out_acc;
  logic       full;
  logic       last_out;

  assign edge_left  = '{valid: 1'b1, gt: 1'b0, value: '0};
  assign edge_right = '{valid: 1'b0, gt: 1'b0, value: '0};

  assign full     = link[DEPTH-1].valid;
  assign in_acc   = in_ch.valid && in_ch.ready;
  assign out_acc  = out_ch.valid && out_ch.ready;
  assign last_out = !link[1].valid;

  assign in_ch.ready = (state_r == ST_LOAD);

  assign ctrl.ins   = in_acc && !full;
  assign ctrl.shift = out_acc;
  assign ctrl.x     = in_ch.value;

  assign out_ch.valid        = (state_r == ST_DRAIN) && link[0].valid;
  assign out_ch.sorted_value = link[0].value;
  assign out_ch.end_of_list  = last_out;
  assign out_ch.overflow     = dropped_r;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_link_t l_in;
    cell_link_t r_in;
    if (i == 0) begin : g_first
      assign l_in = edge_left;
    end else begin : g_mid_l
      assign l_in = link[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign r_in = edge_right;
    end else begin : g_mid_r
      assign r_in = link[i+1];
    end
    ise_cell u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (ctrl),
      .left  (l_in),
      .right (r_in),
      .self  (link[i])
    );
  end

  always_comb begin
    state_nxt   = state_r;
    dropped_nxt = dropped_r;
    case (state_r)
      ST_LOAD: begin
        if (in_acc) begin
          if (full) begin
            dropped_nxt = 1'b1;
          end
          if (in_ch.final_req) begin
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        // leave after the largest entry is taken
        if (out_acc && last_out) begin
          state_nxt   = ST_LOAD;
          dropped_nxt = 1'b0;
        end
      end
      default: begin
        state_nxt   = ST_LOAD;
        dropped_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_LOAD;
      dropped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      dropped_r <= dropped_nxt;
    end
  end

endmodule

// File: rtl/core/ise_cell.sv
// One slot of the sorting chain: holds an entry, inserts and shifts.
module ise_cell import ise_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctrl_t ctrl,
  input  cell_link_t left,
  input  cell_link_t right,
  output cell_link_t self
);

  logic  valid_r, valid_nxt;
  data_t value_r, value_nxt;
  logic  gt;
  logic  take;

  // Strictly greater keeps equal values in arrival order.
  assign gt   = valid_r && (value_r > ctrl.x);
  assign take = gt || (!valid_r && left.valid);

  always_comb begin
    valid_nxt = valid_r;
    value_nxt = value_r;
    if (ctrl.shift) begin
      valid_nxt = right.valid;
      value_nxt = right.value;
    end else if (ctrl.ins && take) begin
      valid_nxt = 1'b1;
      // move the left entry up if it also exceeds the new item
      value_nxt = left.gt ? left.value : ctrl.x;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

  assign self.valid = valid_r;
  assign self.gt    = gt;
  assign self.value = value_r;

endmodule

// File: sim/testbench.sv
// Self-checking testbench for insertion_sort_engine_unit: random lists against a stable-sort scoreboard.
module testbench;
  import ise_pkg::*;

  localparam int RANDOM_ITEMS = 250;
  localparam int STALL_LIMIT  = 2000;
  localparam int DRAIN_SLACK  = 8;
  localparam int PRINT_CAP    = 20;

  typedef struct {
    data_t sorted_value;
    logic  end_of_list;
    logic  overflow;
  } sorted_item_t;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;

  class stable_sort_scoreboard;
    data_t        held_values[$];
    bit           values_dropped = 1'b0;
    sorted_item_t expected_sorted[$];
    int           mismatches = 0;

    task report_mismatch(string what);
      mismatches++;
      if (mismatches <= PRINT_CAP) $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Insert one accepted value; on the final item, queue the whole sorted list.
    function void note_value(data_t v, logic fin);
      int pos;
      int n;
      if (held_values.size() >= DEPTH) begin
        values_dropped = 1'b1;
      end else begin
        pos = held_values.size();
        // strict greater-than keeps equal values in arrival order
        while (pos > 0 && held_values[pos-1] > v) pos--;
        held_values.insert(pos, v);
      end
      if (fin) begin
        n = held_values.size();
        for (int i = 0; i < n; i++)
          expected_sorted.push_back('{held_values[i], i == n - 1, values_dropped});
        held_values.delete();
        values_dropped = 1'b0;
      end
    endfunction

    task check_result(data_t v, logic eol, logic ovf);
      sorted_item_t exp_item;
      if (expected_sorted.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d", v));
      end else begin
        exp_item = expected_sorted.pop_front();
        if (v !== exp_item.sorted_value)
          report_mismatch($sformatf("sorted_value %0d, want %0d", v, exp_item.sorted_value));
        if (eol !== exp_item.end_of_list)
          report_mismatch($sformatf("end_of_list %b, want %b on value %0d",
                                    eol, exp_item.end_of_list, exp_item.sorted_value));
        if (ovf !== exp_item.overflow)
          report_mismatch($sformatf("overflow %b, want %b on value %0d",
                                    ovf, exp_item.overflow, exp_item.sorted_value));
      end
    endtask

    function int pending_count();
      return expected_sorted.size();
    endfunction

    task check_leftovers();
      if (expected_sorted.size() != 0)
        report_mismatch($sformatf("%0d results never arrived", expected_sorted.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;

  stable_sort_scoreboard tracker = new();

  ise_in_if  in_ch ();
  ise_out_if out_ch ();

  insertion_sort_engine_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic data_t pick_value();
    case ($urandom_range(9))
      0: return {1'b1, {(DATA_W-1){1'b0}}};
      1: return {1'b0, {(DATA_W-1){1'b1}}};
      2, 3, 4: return data_t'($urandom_range(0, 15)) - 8;  // small range: duplicates
      default: return data_t'($urandom);
    endcase
  endfunction

  task automatic set_idling(idle_mode_t mode);
    send_idle_pct  = (mode == IDLE_SEND) ? 79 : (mode == IDLE_BOTH) ? 15 : 0;
    recv_stall_pct = (mode == IDLE_RECV) ? 79 : (mode == IDLE_BOTH) ? 15 : 0;
  endtask

  // Offer one item; valid stays high into the next item unless an idle gap is drawn.
  task automatic send_item(data_t v, logic fin);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.value     <= v;
    in_ch.final_req <= fin;
    do @(posedge clk); while (!in_ch.ready);
    tracker.note_value(v, fin);
  endtask

  task automatic send_list(data_t vals[$]);
    foreach (vals[i]) send_item(vals[i], i == vals.size() - 1);
  endtask

  // Result side: check on each handshake, then draw the next ready.
  initial begin
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_ch.valid && out_ch.ready)
        tracker.check_result(out_ch.sorted_value, out_ch.end_of_list, out_ch.overflow);
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : watchdog
    int stalled_cycles;
    stalled_cycles = 0;
    while (stalled_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        stalled_cycles = 0;
      else
        stalled_cycles++;
    end
    $display("== FAIL ==");
    $finish;
  end

  initial begin : stimulus
    data_t      most_neg;
    data_t      most_pos;
    int         sent;
    int         list_len;
    idle_mode_t mode;
    idle_mode_t last_mode;
    most_neg = {1'b1, {(DATA_W-1){1'b0}}};
    most_pos = {1'b0, {(DATA_W-1){1'b1}}};
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.value     <= '0;
    in_ch.final_req <= 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: one-entry lists, extremes with duplicates, reverse order, equal values.
    set_idling(IDLE_NONE);
    send_list('{data_t'(0)});
    send_list('{most_neg});
    send_list('{most_pos, most_neg, -1, 0, 1, most_pos, most_neg, -1});
    send_list('{40, 30, 20, 10, -10});
    send_list('{7, 7, 7, 7});

    // Random lists; a full list and an overflowing one open their phases.
    sent = 0;
    last_mode = IDLE_BOTH;
    while (sent < RANDOM_ITEMS) begin
      mode = idle_mode_t'(sent * 4 / RANDOM_ITEMS);
      set_idling(mode);
      if (mode != last_mode && mode == IDLE_NONE)
        list_len = DEPTH;
      else if (mode != last_mode && mode == IDLE_RECV)
        list_len = DEPTH + 3;  // final value arrives while full and is dropped
      else if ($urandom_range(9) == 0)
        list_len = $urandom_range(DEPTH - 4, DEPTH + 6);
      else
        list_len = $urandom_range(1, 8);
      last_mode = mode;
      for (int i = 0; i < list_len; i++) send_item(pick_value(), i == list_len - 1);
      sent += list_len;
    end
    in_ch.valid <= 1'b0;

    while (tracker.pending_count() != 0) @(posedge clk);
    repeat (DRAIN_SLACK) @(posedge clk);
    tracker.check_leftovers();
    if (tracker.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// File: sim.f
rtl/core/ise_pkg.sv
rtl/core/ise_if.sv
rtl/core/ise_cell.sv
rtl/core/insertion_sort_engine_unit.sv
sim/testbench.sv
